// ===== sv/fnl_pkg.sv =====
// shared types, constants and command codes for the float natural log block
`default_nettype none
package fnl_pkg;

  localparam int SERIES_TERMS = 10;
  localparam int EXP_W        = 10;
  localparam int MAN_W        = 24;
  localparam int ACC_W        = 50;
  localparam int QUO_W        = 26;
  localparam int K_W          = $clog2(SERIES_TERMS);
  localparam int CNT_W        = $clog2(QUO_W);

  // unpacked float: value = man * 2^(exp - 23), man[23] set unless zero
  typedef struct packed {
    logic                    zero;
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
    logic [MAN_W-1:0]        man;
  } flt_t;

  typedef logic [1:0] fop_t;
  localparam fop_t FOP_ADD  = 2'd0;
  localparam fop_t FOP_MUL  = 2'd1;
  localparam fop_t FOP_DIV  = 2'd2;
  localparam fop_t FOP_ITOF = 2'd3;

  typedef logic [3:0] sel_t;
  localparam sel_t SEL_M   = 4'd0;
  localparam sel_t SEL_S   = 4'd1;
  localparam sel_t SEL_S2  = 4'd2;
  localparam sel_t SEL_P   = 4'd3;
  localparam sel_t SEL_D   = 4'd4;
  localparam sel_t SEL_SUM = 4'd5;
  localparam sel_t SEL_T   = 4'd6;
  localparam sel_t SEL_E   = 4'd7;
  localparam sel_t SEL_ONE = 4'd8;
  localparam sel_t SEL_TWO = 4'd9;
  localparam sel_t SEL_LN2 = 4'd10;

  typedef logic [1:0] ccode_t;
  localparam ccode_t CC_NORMAL = 2'd0;
  localparam ccode_t CC_NEG    = 2'd1;
  localparam ccode_t CC_ZERO   = 2'd2;
  localparam ccode_t CC_PASS   = 2'd3;

  localparam flt_t FLT_ONE  = '{zero: 1'b0, sign: 1'b0, exp: 10'sd0, man: 24'h800000};
  localparam flt_t FLT_TWO  = '{zero: 1'b0, sign: 1'b0, exp: 10'sd1, man: 24'h800000};
  localparam flt_t FLT_LN2  = '{zero: 1'b0, sign: 1'b0, exp: -10'sd1, man: 24'hB17218};
  localparam flt_t FLT_ZERO = '{zero: 1'b1, sign: 1'b0, exp: 10'sd0, man: 24'h000000};

  localparam logic [31:0] QNAN_BITS    = 32'h7FC00000;
  localparam logic [31:0] NEG_INF_BITS = 32'hFF800000;

  typedef struct packed {
    logic load;
    logic start;
    fop_t op;
    sel_t a_sel;
    sel_t b_sel;
    logic b_neg;
    logic wr;
    sel_t dst;
    logic init;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic   fpu_done;
    ccode_t in_code;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/float_natural_log.sv =====
// float_natural_log: natural log of one single-precision word per request
//
// channels: in_valid/in_ready carry in_operand_bits (raw single bits);
// out_valid/out_ready carry out_log_bits and out_case_code
// (0 normal, 1 negative gives nan, 2 zero or subnormal gives -inf,
// 3 plus inf or any nan passed through).
// one word is worked on at a time. a normal operand goes through a fixed
// program on one shared float unit: m-1, m+1, one divide, s*s, exponent
// conversion, then per series term a divide, two adds and a multiply, and
// three closing ops, with 10 series terms. a divide op runs in the
// bit-serial divider; the time from accept to out_valid varies with
// the normalize shifts. special operands skip the program and go from
// the check state straight to the emit state.
// a finished word sits in the output register until taken; the next operand
// is accepted meanwhile, and its result waits in the emit state until then.
// reset (synchronous, active low) drops out_valid and returns to idle.
`default_nettype none
module float_natural_log import fnl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_operand_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_log_bits,
  output logic [1:0]       out_case_code
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns handshakes and the op program
  fnl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // operand registers, float unit and output word
  fnl_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operand_bits (in_operand_bits),
    .sts             (sts),
    .out_log_bits    (out_log_bits),
    .out_case_code   (out_case_code)
  );

endmodule
`default_nettype wire

// ===== sv/fnl_fpu.sv =====
// shared single-precision unit: add, multiply, bit-serial divide, int to float, rounding
`default_nettype none
module fnl_fpu import fnl_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire fop_t              op,
  input  wire flt_t              a,
  input  wire flt_t              b,
  input  wire logic              b_neg,
  input  wire logic signed [7:0] int_val,
  output logic                   done,
  output flt_t                   res
);

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_DIV  = 2'd1;
  localparam logic [1:0] FS_NORM = 2'd2;
  localparam logic [1:0] FS_RND  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [ACC_W-1:0]        u_man_r;
  logic                    u_stk_r;
  logic signed [EXP_W-1:0] u_exp_r;
  logic                    u_sign_r;
  logic                    u_zero_r;
  logic [QUO_W-1:0]        rem_r;
  logic [QUO_W-1:0]        quo_r;
  logic [MAN_W-1:0]        dsr_r;
  logic [CNT_W-1:0]        cnt_r;

  // operand setup
  flt_t                    bb, lg, sm;
  logic                    a_big;
  logic signed [EXP_W:0]   ediff;
  logic [5:0]              ash;
  logic [ACC_W-1:0]        add_a, add_b0, add_bt, add_sum;
  logic                    add_stk;
  logic [2*MAN_W-1:0]      prod;
  logic [7:0]              mag;

  always_comb begin
    bb      = b;
    bb.sign = b.sign ^ b_neg;
    a_big   = b.zero | (!a.zero & ((a.exp > b.exp) | ((a.exp == b.exp) & (a.man >= b.man))));
    lg      = a_big ? a : bb;
    sm      = a_big ? bb : a;
    ediff   = (EXP_W+1)'(lg.exp) - (EXP_W+1)'(sm.exp);
    ash     = (sm.zero || (ediff > (EXP_W+1)'(ACC_W-1))) ? 6'(ACC_W) : ediff[5:0];
    add_a   = {1'b0, lg.man, (ACC_W-MAN_W-1)'(0)};
    add_b0  = sm.zero ? '0 : {1'b0, sm.man, (ACC_W-MAN_W-1)'(0)};
    add_bt  = add_b0 >> ash;
    add_stk = |(add_b0 & ~({ACC_W{1'b1}} << ash));
    // effective subtract folds the lost bits in as a borrow
    if ((lg.sign ^ sm.sign) && !sm.zero) begin
      add_sum = add_a - add_bt - ACC_W'(add_stk);
    end else begin
      add_sum = add_a + add_bt;
    end
    prod = a.man * b.man;
    mag  = int_val[7] ? 8'(-int_val) : 8'(int_val);
  end

  // divide step
  logic             div_ge;
  logic [QUO_W-1:0] rem_d;
  logic [QUO_W-1:0] quo_d;

  always_comb begin
    div_ge = rem_r >= QUO_W'(dsr_r);
    rem_d  = div_ge ? rem_r - QUO_W'(dsr_r) : rem_r;
    quo_d  = {quo_r[QUO_W-2:0], div_ge};
  end

  // rounding with gradual underflow, result renormalized
  logic signed [EXP_W:0] shf;
  logic [5:0]            sh;
  logic [ACC_W-1:0]      ms;
  logic                  sst, rg, rst, inc;
  logic [MAN_W-1:0]      rr;
  logic [MAN_W:0]        r25;
  logic [2*MAN_W:0]      w;

  always_comb begin
    shf = (EXP_W+1)'(-126) - (EXP_W+1)'(u_exp_r);
    if (shf <= (EXP_W+1)'(0)) begin
      sh = '0;
    end else if (shf > (EXP_W+1)'(ACC_W)) begin
      sh = 6'(ACC_W);
    end else begin
      sh = shf[5:0];
    end
    ms  = u_man_r >> sh;
    sst = |(u_man_r & ~({ACC_W{1'b1}} << sh));
    rr  = ms[ACC_W-1:ACC_W-MAN_W];
    rg  = ms[ACC_W-MAN_W-1];
    rst = (|ms[ACC_W-MAN_W-2:0]) | u_stk_r | sst;
    inc = rg & (rst | rr[0]);
    r25 = {1'b0, rr} + (MAN_W+1)'(inc);
    w   = (2*MAN_W+1)'(r25) << sh;
    res      = '0;
    res.sign = u_sign_r;
    if (u_zero_r || (r25 == '0)) begin
      res.zero = 1'b1;
    end else if (sh > 6'(MAN_W-1)) begin
      res.exp = EXP_W'(-149);
      res.man = {1'b1, (MAN_W-1)'(0)};
    end else if (w[MAN_W]) begin
      res.exp = u_exp_r + 1'b1;
      res.man = w[MAN_W:1];
    end else begin
      res.exp = u_exp_r;
      res.man = w[MAN_W-1:0];
    end
    done = (state_r == FS_RND);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE: begin
        if (start) begin
          state_nxt = (op == FOP_DIV && !a.zero) ? FS_DIV : FS_NORM;
        end
      end
      FS_DIV: begin
        if (cnt_r == CNT_W'(QUO_W-1)) begin
          state_nxt = FS_NORM;
        end
      end
      FS_NORM: begin
        if (u_zero_r || u_man_r[ACC_W-1] || (u_man_r == '0)) begin
          state_nxt = FS_RND;
        end
      end
      FS_RND: begin
        state_nxt = FS_IDLE;
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      FS_IDLE: begin
        if (start) begin
          unique case (op)
            FOP_ADD: begin
              u_man_r  <= add_sum;
              u_stk_r  <= add_stk;
              u_exp_r  <= lg.exp + 1'b1;
              u_sign_r <= lg.zero ? (a.sign & bb.sign) : lg.sign;
              u_zero_r <= lg.zero | ((add_sum == '0) & !add_stk);
            end
            FOP_MUL: begin
              u_man_r  <= {prod, 2'b00};
              u_stk_r  <= 1'b0;
              u_exp_r  <= a.exp + b.exp + 1'b1;
              u_sign_r <= a.sign ^ b.sign;
              u_zero_r <= a.zero | b.zero;
            end
            FOP_DIV: begin
              u_man_r  <= '0;
              u_stk_r  <= 1'b0;
              u_exp_r  <= a.exp - b.exp;
              u_sign_r <= a.sign ^ b.sign;
              u_zero_r <= a.zero;
              rem_r    <= QUO_W'(a.man);
              dsr_r    <= b.man;
              quo_r    <= '0;
              cnt_r    <= '0;
            end
            FOP_ITOF: begin
              u_man_r  <= {mag[6:0], (ACC_W-7)'(0)};
              u_stk_r  <= 1'b0;
              u_exp_r  <= EXP_W'(6);
              u_sign_r <= int_val[7];
              u_zero_r <= (int_val == '0);
            end
            default: ;
          endcase
        end
      end
      FS_DIV: begin
        rem_r <= {rem_d[QUO_W-2:0], 1'b0};
        quo_r <= quo_d;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W-1)) begin
          u_man_r <= {quo_d, (ACC_W-QUO_W)'(0)};
          u_stk_r <= (rem_d != '0);
        end
      end
      FS_NORM: begin
        if (!u_zero_r && !u_man_r[ACC_W-1]) begin
          if (u_man_r == '0) begin
            u_zero_r <= 1'b1;
          end else begin
            u_man_r <= {u_man_r[ACC_W-2:0], 1'b0};
            u_exp_r <= u_exp_r - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == FS_IDLE) else $error("fpu started while busy");
  a_rnd_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FS_RND && !u_zero_r) |-> u_man_r[ACC_W-1])
    else $error("rounding an unnormalized word");
  a_res_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !res.zero) |-> res.man[MAN_W-1]) else $error("result not normalized");
`endif

endmodule
`default_nettype wire

// ===== sv/fnl_datapath.sv =====
// operand registers, input classification and output word for the log block
`default_nettype none
module fnl_datapath import fnl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  input  wire logic [31:0] in_operand_bits,
  output sts_t             sts,
  output logic [31:0]      out_log_bits,
  output logic [1:0]       out_case_code
);

  logic [31:0] opnd_r;
  flt_t        m_r, s_r, s2_r, p_r, d_r, sum_r, t_r, e_r;
  logic [31:0] log_r;
  ccode_t      code_r;

  flt_t              opa, opb, fres;
  logic              fdone;
  logic signed [7:0] ebias;
  ccode_t            in_code;
  logic [7:0]        bexp;
  logic [31:0]       sum_bits;

  always_comb begin
    bexp  = opnd_r[30:23];
    ebias = 8'(bexp - 8'd127);
    priority if (bexp == 8'hFF && (opnd_r[22:0] != '0 || !opnd_r[31])) begin
      in_code = CC_PASS;
    end else if (bexp == 8'h00) begin
      in_code = CC_ZERO;
    end else if (opnd_r[31]) begin
      in_code = CC_NEG;
    end else begin
      in_code = CC_NORMAL;
    end
    if (sum_r.zero) begin
      sum_bits = {sum_r.sign, 31'd0};
    end else begin
      sum_bits = {sum_r.sign, 8'(sum_r.exp + EXP_W'(127)), sum_r.man[MAN_W-2:0]};
    end
  end

  always_comb begin
    unique case (cmd.a_sel)
      SEL_M:   opa = m_r;
      SEL_S:   opa = s_r;
      SEL_S2:  opa = s2_r;
      SEL_P:   opa = p_r;
      SEL_D:   opa = d_r;
      SEL_SUM: opa = sum_r;
      SEL_T:   opa = t_r;
      SEL_E:   opa = e_r;
      SEL_ONE: opa = FLT_ONE;
      SEL_TWO: opa = FLT_TWO;
      SEL_LN2: opa = FLT_LN2;
      default: opa = FLT_ZERO;
    endcase
    unique case (cmd.b_sel)
      SEL_M:   opb = m_r;
      SEL_S:   opb = s_r;
      SEL_S2:  opb = s2_r;
      SEL_P:   opb = p_r;
      SEL_D:   opb = d_r;
      SEL_SUM: opb = sum_r;
      SEL_T:   opb = t_r;
      SEL_E:   opb = e_r;
      SEL_ONE: opb = FLT_ONE;
      SEL_TWO: opb = FLT_TWO;
      SEL_LN2: opb = FLT_LN2;
      default: opb = FLT_ZERO;
    endcase
  end

  fnl_fpu u_fpu (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.start),
    .op      (cmd.op),
    .a       (opa),
    .b       (opb),
    .b_neg   (cmd.b_neg),
    .int_val (ebias),
    .done    (fdone),
    .res     (fres)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opnd_r <= in_operand_bits;
      m_r    <= '{zero: 1'b0, sign: 1'b0, exp: '0, man: {1'b1, in_operand_bits[22:0]}};
    end
    if (cmd.init) begin
      p_r   <= s_r;
      d_r   <= FLT_ONE;
      sum_r <= FLT_ZERO;
    end
    if (cmd.wr) begin
      unique case (cmd.dst)
        SEL_S:   s_r   <= fres;
        SEL_S2:  s2_r  <= fres;
        SEL_P:   p_r   <= fres;
        SEL_D:   d_r   <= fres;
        SEL_SUM: sum_r <= fres;
        SEL_T:   t_r   <= fres;
        SEL_E:   e_r   <= fres;
        default: ;
      endcase
    end
    if (cmd.emit) begin
      code_r <= in_code;
      unique case (in_code)
        CC_PASS:   log_r <= opnd_r;
        CC_ZERO:   log_r <= NEG_INF_BITS;
        CC_NEG:    log_r <= QNAN_BITS;
        CC_NORMAL: log_r <= sum_bits;
        default:   log_r <= sum_bits;
      endcase
    end
  end

  assign sts.fpu_done  = fdone;
  assign sts.in_code   = in_code;
  assign out_log_bits  = log_r;
  assign out_case_code = code_r;

endmodule
`default_nettype wire

// ===== sv/fnl_ctrl.sv =====
// sequencer for the log series: issues one float operation at a time
`default_nettype none
module fnl_ctrl import fnl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [2:0] CS_IDLE  = 3'd0;
  localparam logic [2:0] CS_CHECK = 3'd1;
  localparam logic [2:0] CS_ISSUE = 3'd2;
  localparam logic [2:0] CS_WAIT  = 3'd3;
  localparam logic [2:0] CS_EMIT  = 3'd4;

  localparam logic [3:0] P_SUB  = 4'd0;
  localparam logic [3:0] P_ADD1 = 4'd1;
  localparam logic [3:0] P_DIV0 = 4'd2;
  localparam logic [3:0] P_SQ   = 4'd3;
  localparam logic [3:0] P_ITOF = 4'd4;
  localparam logic [3:0] P_INIT = 4'd5;
  localparam logic [3:0] P_TDIV = 4'd6;
  localparam logic [3:0] P_ACC  = 4'd7;
  localparam logic [3:0] P_PWR  = 4'd8;
  localparam logic [3:0] P_DEN  = 4'd9;
  localparam logic [3:0] P_DBL  = 4'd10;
  localparam logic [3:0] P_ELN  = 4'd11;
  localparam logic [3:0] P_FIN  = 4'd12;

  logic [2:0]     state_r, state_nxt;
  logic [3:0]     step_r, step_nxt;
  logic [K_W-1:0] k_r, k_nxt;
  logic           out_valid_r, out_valid_nxt;

  always_comb begin
    cmd = '0;
    unique case (step_r)
      P_SUB: begin
        cmd.op = FOP_ADD; cmd.a_sel = SEL_M; cmd.b_sel = SEL_ONE;
        cmd.b_neg = 1'b1; cmd.dst = SEL_T;
      end
      P_ADD1: begin
        cmd.op = FOP_ADD; cmd.a_sel = SEL_M; cmd.b_sel = SEL_ONE; cmd.dst = SEL_D;
      end
      P_DIV0: begin
        cmd.op = FOP_DIV; cmd.a_sel = SEL_T; cmd.b_sel = SEL_D; cmd.dst = SEL_S;
      end
      P_SQ: begin
        cmd.op = FOP_MUL; cmd.a_sel = SEL_S; cmd.b_sel = SEL_S; cmd.dst = SEL_S2;
      end
      P_ITOF: begin
        cmd.op = FOP_ITOF; cmd.dst = SEL_E;
      end
      P_TDIV: begin
        cmd.op = FOP_DIV; cmd.a_sel = SEL_P; cmd.b_sel = SEL_D; cmd.dst = SEL_T;
      end
      P_ACC: begin
        cmd.op = FOP_ADD; cmd.a_sel = SEL_SUM; cmd.b_sel = SEL_T; cmd.dst = SEL_SUM;
      end
      P_PWR: begin
        cmd.op = FOP_MUL; cmd.a_sel = SEL_P; cmd.b_sel = SEL_S2; cmd.dst = SEL_P;
      end
      P_DEN: begin
        cmd.op = FOP_ADD; cmd.a_sel = SEL_D; cmd.b_sel = SEL_TWO; cmd.dst = SEL_D;
      end
      P_DBL: begin
        cmd.op = FOP_MUL; cmd.a_sel = SEL_SUM; cmd.b_sel = SEL_TWO; cmd.dst = SEL_SUM;
      end
      P_ELN: begin
        cmd.op = FOP_MUL; cmd.a_sel = SEL_E; cmd.b_sel = SEL_LN2; cmd.dst = SEL_T;
      end
      P_FIN: begin
        cmd.op = FOP_ADD; cmd.a_sel = SEL_SUM; cmd.b_sel = SEL_T; cmd.dst = SEL_SUM;
      end
      default: ;
    endcase
    cmd.load  = in_valid & in_ready;
    cmd.start = (state_r == CS_ISSUE) && (step_r != P_INIT);
    cmd.init  = (state_r == CS_ISSUE) && (step_r == P_INIT);
    cmd.wr    = (state_r == CS_WAIT) && sts.fpu_done;
    cmd.emit  = (state_r == CS_EMIT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          state_nxt = CS_CHECK;
        end
      end
      CS_CHECK: begin
        if (sts.in_code == CC_NORMAL) begin
          state_nxt = CS_ISSUE;
          step_nxt  = P_SUB;
          k_nxt     = '0;
        end else begin
          state_nxt = CS_EMIT;
        end
      end
      CS_ISSUE: begin
        if (step_r == P_INIT) begin
          step_nxt = P_TDIV;
        end else begin
          state_nxt = CS_WAIT;
        end
      end
      CS_WAIT: begin
        if (sts.fpu_done) begin
          state_nxt = CS_ISSUE;
          priority case (step_r)
            P_DEN: begin
              if (k_r == K_W'(SERIES_TERMS-1)) begin
                step_nxt = P_DBL;
                k_nxt    = '0;
              end else begin
                step_nxt = P_TDIV;
                k_nxt    = k_r + 1'b1;
              end
            end
            P_FIN: begin
              state_nxt = CS_EMIT;
            end
            default: step_nxt = step_r + 1'b1;
          endcase
        end
      end
      CS_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      step_r      <= P_SUB;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == CS_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.fpu_done |-> state_r == CS_WAIT) else $error("fpu result with no op pending");
  a_k_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r != '0) |-> (step_r >= P_TDIV && step_r <= P_DEN))
    else $error("term counter live outside the series loop");
`endif

endmodule
`default_nettype wire

// ===== dv/float_natural_log_tb.sv =====
// testbench for float_natural_log: directed and random operands checked against a bit-exact predictor
module float_natural_log_tb;
  import fnl_pkg::*;

  // single-precision constants used by the series program
  localparam logic [31:0] F32_ONE  = 32'h3F800000;
  localparam logic [31:0] F32_TWO  = 32'h40000000;
  localparam logic [31:0] F32_LN2  = 32'h3F317218;
  localparam logic [31:0] F32_SIGN = 32'h80000000;

  // drain this long at the end so a stray extra word would still be seen
  localparam int DRAIN_CYCLES = 1500;
  localparam int RANDOM_WORDS = 100;

  typedef struct packed {
    logic [31:0] log_bits;
    ccode_t      case_code;
  } log_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_operand_bits;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_log_bits;
  logic [1:0]  out_case_code;

  log_result_t pending_logs[$];
  int          mismatch_count;
  int          words_checked;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          hold_request;
  int          hold_left;

  float_natural_log DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operand_bits (in_operand_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_log_bits    (out_log_bits),
    .out_case_code   (out_case_code)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------------------
  // soft single-precision arithmetic, round to nearest even, with gradual
  // underflow; the series powers fall into the subnormal range when s is tiny
  // ---------------------------------------------------------------------------

  // split a float into sign, exponent and integer significand: value = m * 2^e
  function automatic void f32_split(input logic [31:0] f, output bit sgn, output int e,
                                    output logic [23:0] m);
    sgn = f[31];
    if (f[30:23] == 8'd0) begin
      m = {1'b0, f[22:0]};
      e = -149;
    end else begin
      m = {1'b1, f[22:0]};
      e = int'(f[30:23]) - 150;
    end
  endfunction

  // round mag * 2^e to single precision; the lsb of mag may carry a sticky bit
  function automatic logic [31:0] f32_round(input bit sgn, input int e, input logic [127:0] mag);
    int p;
    int sh;
    int msb_exp;
    int ex;
    int biased;
    logic [127:0] q;
    logic [127:0] rem;
    logic [127:0] half;
    if (mag == '0) return {sgn, 31'b0};
    p = 0;
    for (int i = 0; i < 128; i++) if (mag[i]) p = i;
    msb_exp = e + p;
    sh = p - 23;
    // below the normal range the significand loses bits instead
    if (msb_exp < -126) sh = sh + (-126 - msb_exp);
    ex = e + sh;
    if (sh > 127) begin
      q = '0;
    end else if (sh > 0) begin
      q    = mag >> sh;
      rem  = mag - (q << sh);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
    end else begin
      q = mag << (-sh);
    end
    // rounding carried into a new bit
    if (q == (128'd1 << 24)) begin
      q  = q >> 1;
      ex = ex + 1;
    end
    if (!q[23]) return {sgn, 8'd0, q[22:0]};
    biased = ex + 150;
    if (biased >= 255) return {sgn, 8'hFF, 23'b0};
    return {sgn, biased[7:0], q[22:0]};
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    bit sa, sb, st, sg;
    int ea, eb, et, d;
    logic [23:0] ma, mb, mt;
    logic [127:0] xa, xb, mag;
    f32_split(a, sa, ea, ma);
    f32_split(b, sb, eb, mb);
    if (ma == '0 && mb == '0) return {sa & sb, 31'b0};
    if (ma == '0) return b;
    if (mb == '0) return a;
    if (ea < eb) begin
      st = sa; sa = sb; sb = st;
      et = ea; ea = eb; eb = et;
      mt = ma; ma = mb; mb = mt;
    end
    d  = ea - eb;
    xa = {104'b0, ma} << 64;
    // far below the guard bits only a sticky bit survives
    if (d <= 64) xb = {104'b0, mb} << (64 - d);
    else         xb = 128'd1;
    if (sa == sb) begin
      mag = xa + xb;
      sg  = sa;
    end else if (xa >= xb) begin
      mag = xa - xb;
      sg  = sa;
    end else begin
      mag = xb - xa;
      sg  = sb;
    end
    if (mag == '0) return 32'h0;
    return f32_round(sg, ea - 64, mag);
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    bit sa, sb;
    int ea, eb;
    logic [23:0] ma, mb;
    f32_split(a, sa, ea, ma);
    f32_split(b, sb, eb, mb);
    if (ma == '0 || mb == '0) return {sa ^ sb, 31'b0};
    return f32_round(sa ^ sb, ea + eb, {104'b0, ma} * {104'b0, mb});
  endfunction

  // divisor is never zero in the series program
  function automatic logic [31:0] f32_div(input logic [31:0] a, input logic [31:0] b);
    bit sa, sb;
    int ea, eb;
    logic [23:0] ma, mb;
    logic [127:0] num, den, quo, rem;
    f32_split(a, sa, ea, ma);
    f32_split(b, sb, eb, mb);
    if (ma == '0) return {sa ^ sb, 31'b0};
    num = {104'b0, ma} << 100;
    den = {104'b0, mb};
    quo = num / den;
    rem = num % den;
    return f32_round(sa ^ sb, ea - eb - 101, (quo << 1) | (rem != '0));
  endfunction

  // ln(m) by the odd-power atanh series plus e * ln2, all in single precision
  function automatic logic [31:0] series_log(input logic [7:0] bexp, input logic [22:0] mant);
    logic [31:0] m, ev, s, s2, power, denom, sum;
    int ei;
    m  = F32_ONE | {9'b0, mant};
    ei = int'(bexp) - 127;
    ev = (ei < 0) ? f32_round(1'b1, 0, 128'(-ei)) : f32_round(1'b0, 0, 128'(ei));
    s  = f32_div(f32_add(m, F32_ONE ^ F32_SIGN), f32_add(m, F32_ONE));
    s2 = f32_mul(s, s);
    power = s;
    denom = F32_ONE;
    sum   = 32'h0;
    for (int k = 0; k < SERIES_TERMS; k++) begin
      sum   = f32_add(sum, f32_div(power, denom));
      power = f32_mul(power, s2);
      denom = f32_add(denom, F32_TWO);
    end
    return f32_add(f32_mul(F32_TWO, sum), f32_mul(ev, F32_LN2));
  endfunction

  function automatic log_result_t predict_log(input logic [31:0] x);
    log_result_t r;
    if (x[30:23] == 8'hFF && (x[22:0] != '0 || !x[31])) begin
      r = '{log_bits: x, case_code: CC_PASS};
    end else if (x[30:23] == 8'd0) begin
      r = '{log_bits: NEG_INF_BITS, case_code: CC_ZERO};
    end else if (x[31]) begin
      r = '{log_bits: QNAN_BITS, case_code: CC_NEG};
    end else begin
      r = '{log_bits: series_log(x[30:23], x[22:0]), case_code: CC_NORMAL};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one word, idling first at the phase's rate; valid stays up between
  // back-to-back words so it is never dropped and raised in one step
  task automatic send_operand(input logic [31:0] w);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid        <= 1'b1;
    in_operand_bits <= w;
    do @(posedge clk); while (!in_ready);
    pending_logs.push_back(predict_log(w));
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_logs.size() != 0) @(posedge clk);
  endtask

  // mostly positive normals, half of those near one, plus edges and noise
  function automatic logic [31:0] pick_operand();
    int pick;
    logic [7:0]  bexp;
    logic [22:0] mant;
    pick = $urandom_range(99);
    bexp = (pick < 35) ? 8'($urandom_range(134, 120)) : 8'($urandom_range(254, 1));
    case ($urandom_range(3))
      0:       mant = 23'($urandom_range(15));
      1:       mant = 23'h7FFFFF - 23'($urandom_range(15));
      default: mant = 23'($urandom);
    endcase
    if (pick < 70) return {1'b0, bexp, mant};
    if (pick < 80) return $urandom;
    if (pick < 85) return {1'($urandom), 8'hFF, 23'($urandom)};
    if (pick < 92) return {1'($urandom), 8'h00, ($urandom_range(1) != 0) ? 23'($urandom) : 23'h0};
    return {1'b1, bexp, mant};
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: checks every taken word, and owns out_ready and the long hold
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %0s: got %h expected %h (word %0d)", what, got, want, words_checked);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    log_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_logs.size() == 0) begin
          report_mismatch("unexpected word", out_log_bits, 32'h0);
        end else begin
          want = pending_logs.pop_front();
          if (out_log_bits !== want.log_bits)
            report_mismatch("log_bits", out_log_bits, want.log_bits);
          if (out_case_code !== want.case_code)
            report_mismatch("case_code", 32'(out_case_code), 32'(want.case_code));
        end
        words_checked++;
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_special_operands();
    send_operand(32'h00000000);  // plus zero
    send_operand(32'h80000000);  // minus zero
    send_operand(32'h00000001);  // smallest subnormal
    send_operand(32'h807FFFFF);  // largest negative subnormal
    send_operand(32'h7F800000);  // plus infinity passes
    send_operand(32'hFF800000);  // minus infinity is negative
    send_operand(32'h7FC00000);  // quiet nan
    send_operand(32'h7F800001);  // signaling nan
    send_operand(32'hFFFFFFFF);  // negative nan passes
    send_operand(32'hBF800000);  // negative normal
    send_operand(32'h80800000);  // smallest negative normal
  endtask

  task automatic test_series_edges();
    send_operand(32'h3F800000);  // exactly one gives plus zero
    send_operand(32'h3F800001);  // just above one, s underflows in the powers
    send_operand(32'h3F7FFFFF);  // just below one
    send_operand(32'h3FFFFFFF);  // mantissa all ones
    send_operand(32'h40000000);  // two
    send_operand(32'h3F000000);  // one half
    send_operand(32'h00800000);  // smallest normal
    send_operand(32'h7F7FFFFF);  // largest normal
    send_operand(32'h402DF854);  // near e
    send_operand(32'h5A5A5A5A);
    send_operand(32'h25A5A5A5);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_operand(pick_operand());
  endtask

  // receiver holds off long enough for the block to fill and refuse input
  task automatic test_output_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request       = 2500;
    repeat (6) send_operand(pick_operand());
  endtask

  // sender goes quiet until everything is back, then restarts
  task automatic test_drain_pause();
    sender_idle_pct    = 0;
    receiver_stall_pct = 20;
    repeat (4) send_operand(pick_operand());
    wait_all_results();
    repeat (4) send_operand(pick_operand());
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_operand_bits    = '0;
    out_ready          = 1'b0;
    mismatch_count     = 0;
    words_checked      = 0;
    hold_request       = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_operands();
    test_series_edges();
    test_random_phase(0, 0, RANDOM_WORDS);
    test_output_backpressure();
    test_random_phase(81, 0, RANDOM_WORDS);
    test_drain_pause();
    test_random_phase(0, 81, RANDOM_WORDS);
    test_random_phase(35, 35, RANDOM_WORDS);

    wait_all_results();
    // anything extra would show up as an unexpected word here
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // about 450 words under heavy stalls, with margin
  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
sv/fnl_pkg.sv
sv/fnl_fpu.sv
sv/fnl_datapath.sv
sv/fnl_ctrl.sv
sv/float_natural_log.sv
dv/float_natural_log_tb.sv
